/* rtl/core/fbe_pkg.sv */
`default_nettype none
package fbe_pkg;

    localparam int MAX_WIDTH_DEF  = 128;
    localparam int MAX_HEIGHT_DEF = 128;

    localparam int COORD_W = 16;
    localparam int PIX_W   = 32;
    localparam int OP_W    = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [OP_W-1:0] OP_WRITE    = 3'd0;
    localparam logic [OP_W-1:0] OP_READ     = 3'd1;
    localparam logic [OP_W-1:0] OP_FILL_RGB = 3'd2;
    localparam logic [OP_W-1:0] OP_FILL_RAW = 3'd3;
    localparam logic [OP_W-1:0] OP_COPY     = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RED_BITS     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RED_SHIFT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN_BITS   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN_SHIFT  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE_BITS    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE_SHIFT   = 3'd7;

    typedef struct packed {
        logic        start;
        logic [14:0] dividend;
        logic [6:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic       done;
        logic [7:0] quotient;
    } div_rsp_t;

    function automatic logic [3:0] sat_bits(input logic [3:0] b);
        return (b > 4'd8) ? 4'd8 : b;
    endfunction

    function automatic logic [PIX_W-1:0] pack_chan(input logic [7:0] c,
                                                   input logic [3:0] bits,
                                                   input logic [4:0] shift);
        logic [3:0] b;
        logic [7:0] v;
        b = sat_bits(bits);
        v = (b == 4'd0) ? 8'd0 : (c >> (4'd8 - b));
        return {24'd0, v} << shift;
    endfunction

endpackage
`default_nettype wire

/* rtl/core/fbe_store.sv */
`default_nettype none
module fbe_store #(
    parameter int DEPTH = 16384,
    parameter int AW    = 14
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [AW-1:0]            waddr,
    input  wire logic [fbe_pkg::PIX_W-1:0] wdata,
    input  wire logic [AW-1:0]            raddr,
    output logic      [fbe_pkg::PIX_W-1:0] rdata
);

    logic [fbe_pkg::PIX_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

/* rtl/core/fbe_div.sv */
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module fbe_div (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire fbe_pkg::div_req_t req,
    output fbe_pkg::div_rsp_t      rsp
);

    logic [14:0] num_reg;
    logic [6:0]  rem_reg;
    logic [6:0]  den_reg;
    logic [3:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [7:0]  trial;
    logic        fits;

    assign trial = {rem_reg, num_reg[14]};
    assign fits  = (trial >= {1'b0, den_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 4'd0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 4'd0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 4'd1;
                if (cnt_reg == 4'd14) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            num_reg <= req.dividend;
            den_reg <= req.divisor;
            rem_reg <= 7'd0;
        end else if (busy_reg) begin
            rem_reg <= fits ? 7'(trial - {1'b0, den_reg}) : trial[6:0];
            num_reg <= {num_reg[13:0], fits};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = num_reg[7:0];

endmodule
`default_nettype wire

/* rtl/core/framebuffer_blit_engine_core.sv */
`default_nettype none
// 2D blitter over a MAX_WIDTH x MAX_HEIGHT store of 32-bit pixels, one item in
// flight at a time. After reset a clearing pass zeroes every store word, one
// word per cycle, with s_tready low. From acceptance to the result item: a pixel
// write goes DECODE, FIN; a pixel read goes DECODE, RD_DATA, then CH_GO per
// channel plus CH_WAIT for each channel of 1..7 bits (the shared serial divider
// expands each such channel), then FIN; a fill writes its pixels in FILL between
// DECODE and FIN; a copy goes DECODE, CP_CLIP, CP_INIT, then CP_RD and CP_WR per
// pixel (registered store read, then store write), then FIN. Rejected commands
// go DECODE, FIN. While the previous result item waits on m_tready the block
// holds; s_tready returns as m_tvalid rises. Every item returns one result item.
module framebuffer_blit_engine_core #(
    parameter int MAX_WIDTH  = fbe_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = fbe_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // first_x, first_y, second_x, second_y, span_w, span_h,
    // in_red, in_green, in_blue, raw_word
    input  wire logic [151:0] s_tdata,
    // op
    input  wire logic [2:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // out_red, out_green, out_blue
    output logic [23:0]       m_tdata,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [7:0]   cfg_data
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = fbe_pkg::COORD_W + 1;

    localparam logic [3:0] ST_CLEAR   = 4'd0;
    localparam logic [3:0] ST_IDLE    = 4'd1;
    localparam logic [3:0] ST_DECODE  = 4'd2;
    localparam logic [3:0] ST_RD_DATA = 4'd3;
    localparam logic [3:0] ST_CH_GO   = 4'd4;
    localparam logic [3:0] ST_CH_WAIT = 4'd5;
    localparam logic [3:0] ST_FILL    = 4'd6;
    localparam logic [3:0] ST_CP_CLIP = 4'd7;
    localparam logic [3:0] ST_CP_INIT = 4'd8;
    localparam logic [3:0] ST_CP_RD   = 4'd9;
    localparam logic [3:0] ST_CP_WR   = 4'd10;
    localparam logic [3:0] ST_FIN     = 4'd11;

    logic [3:0] state_reg, state_next;
    logic [AW-1:0] clr_addr_reg;

    logic [7:0] frame_width_reg, frame_height_reg;
    logic [3:0] red_bits_reg, green_bits_reg, blue_bits_reg;
    logic [4:0] red_shift_reg, green_shift_reg, blue_shift_reg;

    logic [2:0]  op_reg;
    logic [CW-1:0] ax_reg, ay_reg, bx_reg, by_reg, sw_reg, sh_reg;
    logic [7:0]  r_reg, g_reg, b_reg;
    logic [31:0] raw_reg;

    logic [31:0]   word_reg, pix_reg;
    logic [CW-1:0] cur_x_reg, cur_y_reg, x_end_reg, y_end_reg;
    logic [CW-1:0] cw_reg, hh_reg, ox_reg, oy_reg;
    logic          back_reg;
    logic [1:0]    ch_reg;
    logic [2:0][7:0] res_reg;
    logic          m_valid_reg;
    logic [23:0]   m_data_reg;

    logic [CW-1:0] vw, vh;
    logic          pix_in;
    logic [31:0]   packed_rgb;

    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [31:0]   mem_wdata, mem_rdata;

    logic [3:0] ch_bits, ch_b;
    logic [4:0] ch_shift;
    logic [31:0] ch_field;
    logic [7:0] ch_mask, ch_v;

    fbe_pkg::div_req_t div_req;
    fbe_pkg::div_rsp_t div_rsp;

    logic fill_bad, copy_bad, last_x, last_y;
    logic [CW-1:0] fill_x1, fill_y1, cw1, ch1, cw2, ch2;

    function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] y,
                                              input logic [CW-1:0] x);
        logic [31:0] a;
        a = 32'(y) * 32'(MAX_WIDTH) + 32'(x);
        return a[AW-1:0];
    endfunction

    assign vw = (CW'(frame_width_reg) < CW'(MAX_WIDTH)) ? CW'(frame_width_reg)
                                                        : CW'(MAX_WIDTH);
    assign vh = (CW'(frame_height_reg) < CW'(MAX_HEIGHT)) ? CW'(frame_height_reg)
                                                          : CW'(MAX_HEIGHT);
    assign pix_in = (ax_reg < vw) && (ay_reg < vh);

    assign packed_rgb = fbe_pkg::pack_chan(r_reg, red_bits_reg, red_shift_reg)
                      | fbe_pkg::pack_chan(g_reg, green_bits_reg, green_shift_reg)
                      | fbe_pkg::pack_chan(b_reg, blue_bits_reg, blue_shift_reg);

    assign fill_bad = (bx_reg <= ax_reg) || (by_reg <= ay_reg) || !pix_in;
    assign fill_x1  = (bx_reg > vw) ? vw : bx_reg;
    assign fill_y1  = (by_reg > vh) ? vh : by_reg;

    assign copy_bad = (sw_reg == '0) || (sh_reg == '0) || !pix_in
                   || (bx_reg >= vw) || (by_reg >= vh);
    assign cw1 = (sw_reg > CW'(vw - ax_reg)) ? CW'(vw - ax_reg) : sw_reg;
    assign ch1 = (sh_reg > CW'(vh - ay_reg)) ? CW'(vh - ay_reg) : sh_reg;
    assign cw2 = (cw_reg > CW'(vw - bx_reg)) ? CW'(vw - bx_reg) : cw_reg;
    assign ch2 = (hh_reg > CW'(vh - by_reg)) ? CW'(vh - by_reg) : hh_reg;

    // channel expansion select
    always_comb begin
        case (ch_reg)
            2'd0:    begin ch_bits = red_bits_reg;   ch_shift = red_shift_reg;   end
            2'd1:    begin ch_bits = green_bits_reg; ch_shift = green_shift_reg; end
            default: begin ch_bits = blue_bits_reg;  ch_shift = blue_shift_reg;  end
        endcase
    end
    assign ch_b     = fbe_pkg::sat_bits(ch_bits);
    assign ch_field = pix_reg >> ch_shift;
    assign ch_mask  = 8'((9'd1 << ch_b) - 9'd1);
    assign ch_v     = ch_field[7:0] & ch_mask;

    assign div_req.start    = (state_reg == ST_CH_GO) && (ch_b != 4'd0) && (ch_b != 4'd8);
    assign div_req.dividend = 15'({ch_v[6:0], 8'd0}) - 15'(ch_v[6:0]);
    assign div_req.divisor  = ch_mask[6:0];

    fbe_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = addr_of(cur_y_reg, cur_x_reg);
        mem_wdata = word_reg;
        case (state_reg)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_addr_reg;
                mem_wdata = '0;
            end
            ST_DECODE: begin
                mem_we    = (op_reg == fbe_pkg::OP_WRITE) && pix_in;
                mem_waddr = addr_of(ay_reg, ax_reg);
                mem_wdata = packed_rgb;
            end
            ST_FILL: begin
                mem_we = 1'b1;
            end
            ST_CP_WR: begin
                mem_we    = 1'b1;
                mem_waddr = addr_of(CW'(by_reg + oy_reg), CW'(bx_reg + ox_reg));
                mem_wdata = mem_rdata;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    assign mem_raddr = (state_reg == ST_CP_RD)
                     ? addr_of(CW'(ay_reg + oy_reg), CW'(ax_reg + ox_reg))
                     : addr_of(ay_reg, ax_reg);

    fbe_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign last_x = back_reg ? (ox_reg == '0) : (ox_reg == CW'(cw_reg - 1'b1));
    assign last_y = back_reg ? (oy_reg == '0) : (oy_reg == CW'(hh_reg - 1'b1));

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:   if (clr_addr_reg == AW'(DEPTH - 1)) state_next = ST_IDLE;
            ST_IDLE:    if (s_tvalid) state_next = ST_DECODE;
            ST_DECODE: begin
                case (op_reg)
                    fbe_pkg::OP_READ:
                        state_next = pix_in ? ST_RD_DATA : ST_FIN;
                    fbe_pkg::OP_FILL_RGB, fbe_pkg::OP_FILL_RAW:
                        state_next = fill_bad ? ST_FIN : ST_FILL;
                    fbe_pkg::OP_COPY:
                        state_next = copy_bad ? ST_FIN : ST_CP_CLIP;
                    default:
                        state_next = ST_FIN;
                endcase
            end
            ST_RD_DATA: state_next = ST_CH_GO;
            ST_CH_GO: begin
                if (div_req.start) begin
                    state_next = ST_CH_WAIT;
                end else if (ch_reg == 2'd2) begin
                    state_next = ST_FIN;
                end
            end
            ST_CH_WAIT: begin
                if (div_rsp.done) begin
                    state_next = (ch_reg == 2'd2) ? ST_FIN : ST_CH_GO;
                end
            end
            ST_FILL: begin
                if (CW'(cur_x_reg + 1'b1) == x_end_reg
                        && CW'(cur_y_reg + 1'b1) == y_end_reg) begin
                    state_next = ST_FIN;
                end
            end
            ST_CP_CLIP: state_next = ST_CP_INIT;
            ST_CP_INIT: state_next = ST_CP_RD;
            ST_CP_RD:   state_next = ST_CP_WR;
            ST_CP_WR:   state_next = (last_x && last_y) ? ST_FIN : ST_CP_RD;
            ST_FIN:     if (!m_valid_reg || m_tready) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_CLEAR;
            clr_addr_reg     <= '0;
            m_valid_reg      <= 1'b0;
            frame_width_reg  <= 8'd128;
            frame_height_reg <= 8'd128;
            red_bits_reg     <= 4'd8;
            red_shift_reg    <= 5'd16;
            green_bits_reg   <= 4'd8;
            green_shift_reg  <= 5'd8;
            blue_bits_reg    <= 4'd8;
            blue_shift_reg   <= 5'd0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (state_reg == ST_FIN && (!m_valid_reg || m_tready)) begin
                m_valid_reg <= 1'b1;
            end
            if (cfg_valid) begin
                case (cfg_index)
                    fbe_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                    fbe_pkg::REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                    fbe_pkg::REG_RED_BITS:     red_bits_reg     <= cfg_data[3:0];
                    fbe_pkg::REG_RED_SHIFT:    red_shift_reg    <= cfg_data[4:0];
                    fbe_pkg::REG_GREEN_BITS:   green_bits_reg   <= cfg_data[3:0];
                    fbe_pkg::REG_GREEN_SHIFT:  green_shift_reg  <= cfg_data[4:0];
                    fbe_pkg::REG_BLUE_BITS:    blue_bits_reg    <= cfg_data[3:0];
                    fbe_pkg::REG_BLUE_SHIFT:   blue_shift_reg   <= cfg_data[4:0];
                    default: ;
                endcase
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                op_reg  <= s_tuser;
                ax_reg  <= CW'(s_tdata[15:0]);
                ay_reg  <= CW'(s_tdata[31:16]);
                bx_reg  <= CW'(s_tdata[47:32]);
                by_reg  <= CW'(s_tdata[63:48]);
                sw_reg  <= CW'(s_tdata[79:64]);
                sh_reg  <= CW'(s_tdata[95:80]);
                r_reg   <= s_tdata[103:96];
                g_reg   <= s_tdata[111:104];
                b_reg   <= s_tdata[119:112];
                raw_reg <= s_tdata[151:120];
                res_reg <= '0;
            end
            ST_DECODE: begin
                word_reg  <= (op_reg == fbe_pkg::OP_FILL_RAW) ? raw_reg : packed_rgb;
                cur_x_reg <= ax_reg;
                cur_y_reg <= ay_reg;
                x_end_reg <= fill_x1;
                y_end_reg <= fill_y1;
                cw_reg    <= cw1;
                hh_reg    <= ch1;
                ch_reg    <= 2'd0;
            end
            ST_RD_DATA: begin
                pix_reg <= mem_rdata;
            end
            ST_CH_GO: begin
                if (ch_b == 4'd8) begin
                    res_reg[ch_reg] <= ch_v;
                end
                if (!div_req.start) begin
                    ch_reg <= ch_reg + 2'd1;
                end
            end
            ST_CH_WAIT: begin
                if (div_rsp.done) begin
                    res_reg[ch_reg] <= div_rsp.quotient;
                    ch_reg <= ch_reg + 2'd1;
                end
            end
            ST_FILL: begin
                if (CW'(cur_x_reg + 1'b1) == x_end_reg) begin
                    cur_x_reg <= ax_reg;
                    cur_y_reg <= CW'(cur_y_reg + 1'b1);
                end else begin
                    cur_x_reg <= CW'(cur_x_reg + 1'b1);
                end
            end
            ST_CP_CLIP: begin
                cw_reg   <= cw2;
                hh_reg   <= ch2;
                // overlap-safe order: walk backward when the target lies later
                back_reg <= (by_reg > ay_reg) || (by_reg == ay_reg && bx_reg > ax_reg);
            end
            ST_CP_INIT: begin
                ox_reg <= back_reg ? CW'(cw_reg - 1'b1) : '0;
                oy_reg <= back_reg ? CW'(hh_reg - 1'b1) : '0;
            end
            ST_CP_WR: begin
                if (last_x) begin
                    ox_reg <= back_reg ? CW'(cw_reg - 1'b1) : '0;
                    oy_reg <= back_reg ? CW'(oy_reg - 1'b1) : CW'(oy_reg + 1'b1);
                end else begin
                    ox_reg <= back_reg ? CW'(ox_reg - 1'b1) : CW'(ox_reg + 1'b1);
                end
            end
            ST_FIN: begin
                if (!m_valid_reg || m_tready) begin
                    m_data_reg <= {res_reg[2], res_reg[1], res_reg[0]};
                end
            end
            default: ;
        endcase
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign cfg_ready = 1'b1;

endmodule
`default_nettype wire

/* sim/fbe_checker.sv */
module fbe_checker (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    input  wire logic         s_tready,
    input  wire logic [151:0] s_tdata,
    input  wire logic [2:0]   s_tuser,
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    input  wire logic [23:0]  m_tdata,
    input  wire logic         cfg_valid,
    input  wire logic         cfg_ready,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [7:0]   cfg_data,
    output int                fail_count,
    output int                pending
);
    import fbe_pkg::*;

    localparam int GRID_W = MAX_WIDTH_DEF;
    localparam int GRID_H = MAX_HEIGHT_DEF;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    logic [31:0] frame_mem [GRID_W*GRID_H];
    logic [31:0] copy_buf  [GRID_W*GRID_H];
    logic [7:0]  fb_w, fb_h;
    logic [3:0]  r_bits, g_bits, b_bits;
    logic [4:0]  r_sh, g_sh, b_sh;
    rgb_t        rgb_due [$];

    initial begin
        fail_count = 0;
        pending    = 0;
        for (int i = 0; i < GRID_W*GRID_H; i++) frame_mem[i] = '0;
        fb_w = 8'd128; fb_h = 8'd128;
        r_bits = 4'd8; g_bits = 4'd8; b_bits = 4'd8;
        r_sh = 5'd16; g_sh = 5'd8; b_sh = 5'd0;
    end

    function automatic int unsigned vis_w();
        return (fb_w < GRID_W) ? fb_w : GRID_W;
    endfunction

    function automatic int unsigned vis_h();
        return (fb_h < GRID_H) ? fb_h : GRID_H;
    endfunction

    function automatic logic [31:0] chan_to_word(logic [7:0] c, logic [3:0] nb, logic [4:0] sh);
        int unsigned b;
        logic [31:0] v;
        b = (nb > 8) ? 8 : nb;
        v = (b == 0) ? 32'd0 : (32'(c) >> (8 - b));
        return v << sh;
    endfunction

    function automatic logic [31:0] rgb_to_word(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        return chan_to_word(r, r_bits, r_sh) | chan_to_word(g, g_bits, g_sh)
             | chan_to_word(b, b_bits, b_sh);
    endfunction

    function automatic logic [7:0] word_to_chan(logic [31:0] w, logic [3:0] nb, logic [4:0] sh);
        int unsigned b, v, maxv;
        b = (nb > 8) ? 8 : nb;
        if (b == 0) return 8'd0;
        maxv = (1 << b) - 1;
        v = (w >> sh) & maxv;
        if (b >= 8) return v[7:0];
        v = (v * 255) / maxv;
        return v[7:0];
    endfunction

    task automatic paint_rect(int unsigned x0, int unsigned y0, int unsigned x1,
                              int unsigned y1, logic [31:0] word);
        int unsigned w, h;
        w = vis_w(); h = vis_h();
        if (x1 <= x0 || y1 <= y0 || x0 >= w || y0 >= h) return;
        if (x1 > w) x1 = w;
        if (y1 > h) y1 = h;
        for (int unsigned y = y0; y < y1; y++)
            for (int unsigned x = x0; x < x1; x++)
                frame_mem[y*GRID_W + x] = word;
    endtask

    task automatic move_rect(int unsigned sx, int unsigned sy, int unsigned dx,
                             int unsigned dy, int unsigned cw, int unsigned ch);
        int unsigned w, h;
        w = vis_w(); h = vis_h();
        if (cw == 0 || ch == 0 || sx >= w || dx >= w || sy >= h || dy >= h) return;
        if (sx + cw > w) cw = w - sx;
        if (dx + cw > w) cw = w - dx;
        if (sy + ch > h) ch = h - sy;
        if (dy + ch > h) ch = h - dy;
        // staged through a buffer so overlapping areas act like memmove
        for (int unsigned y = 0; y < ch; y++)
            for (int unsigned x = 0; x < cw; x++)
                copy_buf[y*GRID_W + x] = frame_mem[(sy + y)*GRID_W + sx + x];
        for (int unsigned y = 0; y < ch; y++)
            for (int unsigned x = 0; x < cw; x++)
                frame_mem[(dy + y)*GRID_W + dx + x] = copy_buf[y*GRID_W + x];
    endtask

    task automatic predict_cmd(logic [2:0] op, logic [151:0] d);
        int unsigned ax, ay, bx, by;
        logic [31:0] p;
        rgb_t res;
        ax = d[15:0]; ay = d[31:16]; bx = d[47:32]; by = d[63:48];
        res = '{8'd0, 8'd0, 8'd0};
        case (op)
            OP_WRITE: begin
                if (ax < vis_w() && ay < vis_h())
                    frame_mem[ay*GRID_W + ax] = rgb_to_word(d[103:96], d[111:104], d[119:112]);
            end
            OP_READ: begin
                if (ax < vis_w() && ay < vis_h()) begin
                    p = frame_mem[ay*GRID_W + ax];
                    res.red   = word_to_chan(p, r_bits, r_sh);
                    res.green = word_to_chan(p, g_bits, g_sh);
                    res.blue  = word_to_chan(p, b_bits, b_sh);
                end
            end
            OP_FILL_RGB: paint_rect(ax, ay, bx, by,
                                    rgb_to_word(d[103:96], d[111:104], d[119:112]));
            OP_FILL_RAW: paint_rect(ax, ay, bx, by, d[151:120]);
            OP_COPY:     move_rect(ax, ay, bx, by, d[79:64], d[95:80]);
            default: ;
        endcase
        rgb_due.push_back(res);
    endtask

    task automatic report(string what, logic [7:0] got, logic [7:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        rgb_t want;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_FRAME_WIDTH:  fb_w   = cfg_data;
                    REG_FRAME_HEIGHT: fb_h   = cfg_data;
                    REG_RED_BITS:     r_bits = cfg_data[3:0];
                    REG_RED_SHIFT:    r_sh   = cfg_data[4:0];
                    REG_GREEN_BITS:   g_bits = cfg_data[3:0];
                    REG_GREEN_SHIFT:  g_sh   = cfg_data[4:0];
                    REG_BLUE_BITS:    b_bits = cfg_data[3:0];
                    REG_BLUE_SHIFT:   b_sh   = cfg_data[4:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) predict_cmd(s_tuser, s_tdata);
            if (m_tvalid && m_tready) begin
                if (rgb_due.size() == 0) begin
                    $display("unexpected result item %h at %0t", m_tdata, $realtime);
                    fail_count++;
                end else begin
                    want = rgb_due.pop_front();
                    if (m_tdata[7:0] !== want.red)    report("red", m_tdata[7:0], want.red);
                    if (m_tdata[15:8] !== want.green) report("green", m_tdata[15:8], want.green);
                    if (m_tdata[23:16] !== want.blue) report("blue", m_tdata[23:16], want.blue);
                end
            end
            pending = rgb_due.size();
        end
    end
endmodule

/* sim/tb_top.sv */
module tb_top;
    import fbe_pkg::*;

    localparam int CYCLE_LIMIT = 20000000;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [151:0] s_tdata = '0;
    logic [2:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [23:0]  m_tdata;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [2:0]   cfg_index = '0;
    logic [7:0]   cfg_data = '0;
    int           fail_count;
    int           pending;

    bit           calm = 0;
    bit           hold_long = 0;
    int unsigned  lim_w = 128, lim_h = 128;

    framebuffer_blit_engine_core dut (.*);

    fbe_checker chk (.*);

    initial begin
        forever #10 aclk = ~aclk;
    end

    initial begin
        int unsigned cycles;
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // result side: random ready bursts, steady ready when calm, one long hold on request
    initial begin
        int n;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (hold_long) begin
                hold_long = 0;
                m_tready <= 1'b0;
                repeat (400) @(posedge aclk);
            end else if (calm) begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end else begin
                n = $urandom_range(1, 16);
                m_tready <= ($urandom_range(0, 3) != 0);
                repeat (n) @(posedge aclk);
            end
        end
    end

    task automatic send_cmd(logic [2:0] op, logic [15:0] ax, logic [15:0] ay,
                            logic [15:0] bx, logic [15:0] by, logic [15:0] sw,
                            logic [15:0] sh, logic [7:0] r, logic [7:0] g,
                            logic [7:0] b, logic [31:0] raw);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {raw, b, g, r, sh, sw, by, bx, ay, ax};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (!calm && $urandom_range(0, 9) < 3) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
        @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_mode(logic [7:0] w, logic [7:0] h, logic [3:0] rb, logic [4:0] rs,
                            logic [3:0] gb, logic [4:0] gs, logic [3:0] bb, logic [4:0] bs);
        drain();
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
        write_reg(REG_RED_BITS, {4'd0, rb});
        write_reg(REG_RED_SHIFT, {3'd0, rs});
        write_reg(REG_GREEN_BITS, {4'd0, gb});
        write_reg(REG_GREEN_SHIFT, {3'd0, gs});
        write_reg(REG_BLUE_BITS, {4'd0, bb});
        write_reg(REG_BLUE_SHIFT, {3'd0, bs});
        lim_w = (w < 128) ? w : 128;
        lim_h = (h < 128) ? h : 128;
    endtask

    // mostly near the visible frame, now and then anywhere in 16 bits
    function automatic logic [15:0] pick_coord(int unsigned lim);
        int unsigned k;
        k = $urandom_range(0, 19);
        if (k == 0) return 16'hFFFF;
        if (k < 3) return 16'($urandom_range(0, 65535));
        return 16'($urandom_range(0, lim + 1));
    endfunction

    function automatic logic [15:0] pick_end(logic [15:0] start);
        int unsigned k;
        k = $urandom_range(0, 19);
        if (k == 0) return 16'hFFFF;
        if (k == 1) return 16'($urandom_range(0, 65535));
        if (k == 2) return (start > 3) ? 16'(start - $urandom_range(0, 3)) : 16'd0;
        return 16'(start + $urandom_range(1, 10));
    endfunction

    function automatic logic [15:0] pick_span();
        int unsigned k;
        k = $urandom_range(0, 19);
        if (k == 0) return 16'hFFFF;
        if (k == 1) return 16'($urandom_range(0, 65535));
        return 16'($urandom_range(0, 9));
    endfunction

    task automatic random_cmd();
        int unsigned k;
        logic [2:0]  op;
        logic [15:0] ax, ay;
        k = $urandom_range(0, 99);
        ax = pick_coord(lim_w);
        ay = pick_coord(lim_h);
        if (k < 25)      op = OP_WRITE;
        else if (k < 55) op = OP_READ;
        else if (k < 70) op = OP_FILL_RGB;
        else if (k < 80) op = OP_FILL_RAW;
        else if (k < 95) op = OP_COPY;
        else             op = 3'($urandom_range(5, 7));
        if (op == OP_COPY)
            send_cmd(op, ax, ay, pick_coord(lim_w), pick_coord(lim_h), pick_span(),
                     pick_span(), 8'($urandom), 8'($urandom), 8'($urandom), $urandom);
        else
            send_cmd(op, ax, ay, pick_end(ax), pick_end(ay), 16'($urandom),
                     16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), $urandom);
        // follow writes with a read of the same pixel now and then
        if (op == OP_WRITE && $urandom_range(0, 1) == 1)
            send_cmd(OP_READ, ax, ay, 0, 0, 0, 0, 0, 0, 0, 0);
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part at reset settings
        send_cmd(OP_WRITE, 0, 0, 0, 0, 0, 0, 8'hFF, 8'hFF, 8'hFF, 0);
        send_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_cmd(OP_WRITE, 127, 127, 0, 0, 0, 0, 8'h12, 8'h80, 8'h01, 0);
        send_cmd(OP_READ, 127, 127, 0, 0, 0, 0, 0, 0, 0, 0);
        send_cmd(OP_WRITE, 128, 0, 0, 0, 0, 0, 8'hAA, 8'h55, 8'h0F, 0);
        send_cmd(OP_READ, 128, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_cmd(OP_READ, 16'hFFFF, 16'hFFFF, 0, 0, 0, 0, 0, 0, 0, 0);
        send_cmd(OP_FILL_RGB, 2, 2, 6, 5, 0, 0, 8'h40, 8'hC0, 8'h7F, 0);
        send_cmd(OP_FILL_RAW, 120, 125, 16'hFFFF, 16'hFFFF, 0, 0, 0, 0, 0, 32'hDEADBEEF);
        send_cmd(OP_FILL_RAW, 5, 5, 5, 9, 0, 0, 0, 0, 0, 32'hFFFFFFFF);
        send_cmd(OP_FILL_RGB, 9, 9, 3, 3, 0, 0, 8'hFF, 0, 0, 0);
        send_cmd(OP_FILL_RGB, 128, 0, 130, 4, 0, 0, 8'hFF, 0, 0, 0);
        send_cmd(OP_COPY, 2, 2, 3, 2, 4, 3, 0, 0, 0, 0);
        send_cmd(OP_COPY, 2, 3, 2, 2, 4, 3, 0, 0, 0, 0);
        send_cmd(OP_COPY, 2, 2, 124, 126, 16'hFFFF, 16'hFFFF, 0, 0, 0, 0);
        send_cmd(OP_COPY, 2, 2, 9, 9, 0, 4, 0, 0, 0, 0);
        send_cmd(OP_COPY, 200, 2, 9, 9, 4, 4, 0, 0, 0, 0);
        send_cmd(OP_READ, 3, 2, 0, 0, 0, 0, 0, 0, 0, 0);
        send_cmd(OP_READ, 125, 127, 0, 0, 0, 0, 0, 0, 0, 0);
        send_cmd(3'd5, 1, 1, 2, 2, 1, 1, 8'hFF, 8'hFF, 8'hFF, 32'hFFFFFFFF);
        send_cmd(3'd6, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_cmd(3'd7, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_mode(8'd128, 8'd128, 4'd8, 5'd16, 4'd8, 5'd8, 4'd8, 5'd0);
                1: set_mode(8'd255, 8'd255, 4'd15, 5'd31, 4'd0, 5'd0, 4'd4, 5'd27);
                2: set_mode(8'd1, 8'd1, 4'd1, 5'd0, 4'd2, 5'd30, 4'd7, 5'd9);
                3: set_mode(8'd0, 8'd0, 4'd5, 5'd3, 4'd6, 5'd11, 4'd3, 5'd20);
                default: set_mode(8'($urandom_range(1, 40)), 8'($urandom_range(1, 40)),
                                  4'($urandom_range(0, 15)), 5'($urandom_range(0, 31)),
                                  4'($urandom_range(0, 15)), 5'($urandom_range(0, 31)),
                                  4'($urandom_range(0, 15)), 5'($urandom_range(0, 31)));
            endcase
            if (ph == 5) calm = 1;
            for (int i = 0; i < 40; i++) begin
                if (ph == 1 && i == 5) hold_long = 1;
                if (ph == 2 && i == 18) drain();
                random_cmd();
            end
        end

        drain();
        repeat (100) @(posedge aclk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

/* framebuffer_blit_engine_core.f */
rtl/core/fbe_pkg.sv
rtl/core/fbe_store.sv
rtl/core/fbe_div.sv
rtl/core/framebuffer_blit_engine_core.sv
sim/fbe_checker.sv
sim/tb_top.sv
